/* rtl/fbd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fractional boxcar decimator package
// Shared constants, register indexes and the divider state type.
// ----------------------------------------------------------------------------
package fbd_pkg;

   localparam int LANES            = 4;
   localparam int SAMPLE_BITS_DEF  = 16;
   localparam int SLICE_BITS_DEF   = 8;
   localparam int PHASE_BITS       = 32;
   localparam int PHASE_STEP_BITS  = 24;
   localparam int CSR_DATA_BITS    = 24;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int ACTIVE_BITS      = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SLICE_SHORT  = 3'd0,
      CSR_SLICE_LONG   = 3'd1,
      CSR_PHASE_ADD    = 3'd2,
      CSR_PHASE_SUB    = 3'd3,
      CSR_ACTIVE_LANES = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

endpackage
`default_nettype wire

/* rtl/fractional_boxcar_decimator_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fractional boxcar decimator
// Mixes up to four DAC lanes per step and averages the mix over windows of
// alternating length chosen by a signed phase accumulator.
// ----------------------------------------------------------------------------
// Throughput: one step transfer per cycle. A step that closes its window is
//   held back only while the previous division is still running or its result
//   has not been taken; with a receiver that takes each result at once this
//   happens only for windows shorter than SUM_BITS + 2 steps (28 by default).
// Result: the result of a closing step is offered once the bit-serial divider
//   has worked through every bit of the window sum.
// Reset: synchronous, active high; restores the register defaults, clears the
//   phase accumulator and window state and empties the divider.
// ----------------------------------------------------------------------------
module fractional_boxcar_decimator_top #(
   parameter int SAMPLE_BITS = fbd_pkg::SAMPLE_BITS_DEF,
   parameter int SLICE_BITS  = fbd_pkg::SLICE_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Step channel
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0]        req_lane0_sample,
   input  wire logic signed [SAMPLE_BITS-1:0]        req_lane1_sample,
   input  wire logic signed [SAMPLE_BITS-1:0]        req_lane2_sample,
   input  wire logic signed [SAMPLE_BITS-1:0]        req_lane3_sample,
   // Result channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed      [SAMPLE_BITS-1:0]        rsp_mixed_sample,
   // Register write port
   input  wire logic                                 csr_write_enable,
   input  wire logic [fbd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [fbd_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);
   import fbd_pkg::*;

   // The step sum needs room for the lanes, the window sum for the slice.
   localparam int STEP_BITS = SAMPLE_BITS + $clog2(LANES);
   localparam int SUM_BITS  = STEP_BITS + SLICE_BITS;

   // Configuration registers.
   logic [SLICE_BITS-1:0]      slice_short_ff;
   logic [SLICE_BITS-1:0]      slice_long_ff;
   logic [PHASE_STEP_BITS-1:0] phase_add_ff;
   logic [PHASE_STEP_BITS-1:0] phase_sub_ff;
   logic [ACTIVE_BITS-1:0]     active_lanes_ff;

   // Window state.
   logic [PHASE_BITS-1:0]      phase_ff, phase_in;
   logic [SLICE_BITS-1:0]      count_ff, count_in;
   logic [SLICE_BITS-1:0]      length_ff, length_in;
   logic signed [SUM_BITS-1:0] sum_ff, sum_in;

   logic signed [SAMPLE_BITS-1:0] samples     [LANES];
   logic signed [STEP_BITS-1:0]   lane_values [LANES];
   logic signed [STEP_BITS-1:0]   step_sum;

   logic                       win_open;
   logic                       phase_neg;
   logic [SLICE_BITS-1:0]      raw_len;
   logic [SLICE_BITS-1:0]      start_len;
   logic [SLICE_BITS-1:0]      len_cur;
   logic [SLICE_BITS-1:0]      count_next;
   logic                       closes;
   logic signed [SUM_BITS-1:0] base_sum;
   logic signed [SUM_BITS-1:0] new_sum;
   logic                       fire;
   logic                       div_start;
   logic                       div_idle;

   assign samples[0] = req_lane0_sample;
   assign samples[1] = req_lane1_sample;
   assign samples[2] = req_lane2_sample;
   assign samples[3] = req_lane3_sample;

   // One lane per DAC channel, all working on the same step.
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      fbd_lane #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .STEP_BITS   (STEP_BITS),
         .LANE_INDEX  (g)
      ) u_lane (
         .sample       (samples[g]),
         .active_lanes (active_lanes_ff),
         .lane_value   (lane_values[g])
      );
   end

   fbd_merge #(
      .STEP_BITS (STEP_BITS)
   ) u_merge (
      .lane_values (lane_values),
      .step_sum    (step_sum)
   );

   // Register writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         slice_short_ff  <= SLICE_BITS'(81);
         slice_long_ff   <= SLICE_BITS'(82);
         phase_add_ff    <= '0;
         phase_sub_ff    <= '0;
         active_lanes_ff <= ACTIVE_BITS'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_SLICE_SHORT:  slice_short_ff  <= csr_write_data[SLICE_BITS-1:0];
            CSR_SLICE_LONG:   slice_long_ff   <= csr_write_data[SLICE_BITS-1:0];
            CSR_PHASE_ADD:    phase_add_ff    <= csr_write_data[PHASE_STEP_BITS-1:0];
            CSR_PHASE_SUB:    phase_sub_ff    <= csr_write_data[PHASE_STEP_BITS-1:0];
            CSR_ACTIVE_LANES: active_lanes_ff <= csr_write_data[ACTIVE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // A count of zero means no window is open, so the length in use comes from
   // the phase accumulator: negative picks the long slice. A zero slice is
   // taken as one step, so every step closes its window.
   assign win_open   = count_ff != '0;
   assign phase_neg  = phase_ff[PHASE_BITS-1];
   assign raw_len    = phase_neg ? slice_long_ff : slice_short_ff;
   assign start_len  = (raw_len == '0) ? SLICE_BITS'(1) : raw_len;
   assign len_cur    = win_open ? length_ff : start_len;
   assign count_next = count_ff + 1'b1;
   assign closes     = count_next >= len_cur;
   assign base_sum   = win_open ? sum_ff : '0;
   assign new_sum    = base_sum
                     + {{(SUM_BITS-STEP_BITS){step_sum[STEP_BITS-1]}}, step_sum};

   // Steps inside a window always flow; a closing step needs a free divider.
   assign req_ready = !closes || div_idle;
   assign fire      = req_valid && req_ready;
   assign div_start = fire && closes;

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      length_in = length_ff;
      sum_in    = sum_ff;
      if (fire) begin
         if (!win_open) begin
            length_in = start_len;
            phase_in  = phase_ff
                      + (phase_neg ? PHASE_BITS'(phase_add_ff) : '0)
                      - PHASE_BITS'(phase_sub_ff);
         end
         if (closes) begin
            count_in = '0;
            sum_in   = '0;
         end else begin
            count_in = count_next;
            sum_in   = new_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         count_ff  <= '0;
         length_ff <= '0;
         sum_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         length_ff <= length_in;
         sum_ff    <= sum_in;
      end
   end

   // The divider holds its quotient until the result transfer completes.
   fbd_divider #(
      .SUM_BITS    (SUM_BITS),
      .SLICE_BITS  (SLICE_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (new_sum),
      .divisor   (len_cur),
      .idle      (div_idle),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .quotient  (rsp_mixed_sample)
   );

   // An open window never holds more steps than its latched length.
   a_count_below_length: assert property (@(posedge clock) disable iff (reset)
      win_open |-> (count_ff < length_ff))
      else $error("window count reached its length without closing");

   // No partial sum survives once a window has closed.
   a_closed_sum_clear: assert property (@(posedge clock) disable iff (reset)
      !win_open |-> (sum_ff == '0))
      else $error("window sum not cleared while no window is open");

   // A started division occupies the divider in the next cycle.
   a_start_takes: assert property (@(posedge clock) disable iff (reset)
      div_start |=> !div_idle)
      else $error("division start was lost");

   // No result is offered while the divider claims to be free.
   a_idle_no_result: assert property (@(posedge clock) disable iff (reset)
      div_idle |-> !rsp_valid)
      else $error("result offered by an idle divider");

endmodule
`default_nettype wire

/* rtl/fbd_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fractional boxcar decimator lane
// Gates one DAC sample by the active lane count and widens it for the mix.
// ----------------------------------------------------------------------------
module fbd_lane #(
   parameter int SAMPLE_BITS = fbd_pkg::SAMPLE_BITS_DEF,
   parameter int STEP_BITS   = fbd_pkg::SAMPLE_BITS_DEF + 2,
   parameter int LANE_INDEX  = 0
) (
   input  wire logic signed [SAMPLE_BITS-1:0]          sample,
   input  wire logic        [fbd_pkg::ACTIVE_BITS-1:0] active_lanes,
   output logic      signed [STEP_BITS-1:0]            lane_value
);
   import fbd_pkg::*;

   localparam logic [ACTIVE_BITS-1:0] INDEX = ACTIVE_BITS'(LANE_INDEX);

   logic enabled;

   // A lane takes part when its index lies below the programmed count.
   assign enabled = active_lanes > INDEX;

   always_comb begin
      if (enabled) begin
         lane_value = {{(STEP_BITS-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
      end else begin
         lane_value = '0;
      end
   end

endmodule
`default_nettype wire

/* rtl/fbd_merge.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fractional boxcar decimator merge
// Adds the gated lane values of one step into the step sum.
// ----------------------------------------------------------------------------
module fbd_merge #(
   parameter int STEP_BITS = fbd_pkg::SAMPLE_BITS_DEF + 2
) (
   input  wire logic signed [STEP_BITS-1:0] lane_values [fbd_pkg::LANES],
   output logic      signed [STEP_BITS-1:0] step_sum
);
   import fbd_pkg::*;

   always_comb begin
      step_sum = '0;
      for (int i = 0; i < LANES; i++) begin
         step_sum = step_sum + lane_values[i];
      end
   end

endmodule
`default_nettype wire

/* rtl/fbd_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fractional boxcar decimator divider
// Restoring signed division, one quotient bit a cycle, with a result register.
// ----------------------------------------------------------------------------
module fbd_divider #(
   parameter int SUM_BITS    = 26,
   parameter int SLICE_BITS  = fbd_pkg::SLICE_BITS_DEF,
   parameter int SAMPLE_BITS = fbd_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic signed [SUM_BITS-1:0]    dividend,
   input  wire logic        [SLICE_BITS-1:0]  divisor,
   output logic                               idle,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic             [SAMPLE_BITS-1:0] quotient
);
   import fbd_pkg::*;

   localparam int CNT_BITS = $clog2(SUM_BITS);

   div_state_type           state_ff, state_in;
   logic                    neg_ff, neg_in;
   logic [SUM_BITS-1:0]     dvd_ff, dvd_in;
   logic [SLICE_BITS-1:0]   den_ff, den_in;
   logic [SLICE_BITS-1:0]   rem_ff, rem_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;

   logic [SLICE_BITS:0]     trial;
   logic [SLICE_BITS:0]     diff;
   logic                    take;
   logic [SAMPLE_BITS-1:0]  q_mag;

   assign trial = {rem_ff, dvd_ff[SUM_BITS-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign take  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      neg_ff <= neg_in;
      dvd_ff <= dvd_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      state_in = state_ff;
      neg_in   = neg_ff;
      dvd_in   = dvd_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               neg_in   = dividend[SUM_BITS-1];
               dvd_in   = dividend[SUM_BITS-1] ? ('0 - dividend) : dividend;
               den_in   = divisor;
               rem_in   = '0;
               cnt_in   = CNT_BITS'(SUM_BITS - 1);
               state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            rem_in = take ? diff[SLICE_BITS-1:0] : trial[SLICE_BITS-1:0];
            dvd_in = {dvd_ff[SUM_BITS-2:0], take};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = DIV_DONE;
            end
         end
         DIV_DONE: begin
            if (rsp_ready) begin
               state_in = DIV_IDLE;
            end
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   // Magnitude quotient, then the sign restored: truncation toward zero.
   assign q_mag     = dvd_ff[SAMPLE_BITS-1:0];
   assign quotient  = neg_ff ? ('0 - q_mag) : q_mag;
   assign idle      = state_ff == DIV_IDLE;
   assign rsp_valid = state_ff == DIV_DONE;

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractional boxcar decimator testbench
// Feeds DAC steps through the valid/ready step channel, keeps a cycle-free
// model of the window and phase logic to predict every averaged sample, and
// compares each result transfer against it. A short table of directed steps
// comes first, followed by random phases under changing register settings
// and handshake pressure.
// ----------------------------------------------------------------------------
module tb;

   import fbd_pkg::*;

   // Run limits: the quiet stretch that lets any step in flight show up at the
   // output, the overall cycle cap and the least number of results wanted.
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int unsigned MIN_RESULTS   = 48;

   typedef logic signed [15:0] sample_type;
   typedef logic [0:3][15:0]   step_lanes_type;

   // Directed rows either write a register, send a step whose outcome the
   // model works out, or send a step with the outcome typed in the row.
   typedef enum logic [1:0] {
      ROW_WRITE,
      ROW_STEP,
      ROW_STEP_CHECK
   } row_kind_type;

   typedef struct packed {
      row_kind_type   kind;
      csr_index_type  index;
      logic [23:0]    value;
      step_lanes_type lanes;
      sample_type     mixed;
   } table_row_type;

   localparam int DIRECTED_ROW_COUNT = 40;

   localparam step_lanes_type NO_LANES = {4{16'h0000}};

   localparam table_row_type DIRECTED_ROWS [DIRECTED_ROW_COUNT] = '{
      // One-step windows over all four lanes: the output is the lane sum,
      // wrapped to 16 bits.
      '{ROW_WRITE,      CSR_ACTIVE_LANES, 24'd4, NO_LANES, 16'h0000},
      '{ROW_WRITE,      CSR_SLICE_SHORT,  24'd1, NO_LANES, 16'h0000},
      '{ROW_WRITE,      CSR_SLICE_LONG,   24'd1, NO_LANES, 16'h0000},
      '{ROW_STEP_CHECK, CSR_SLICE_SHORT,  24'd0,
        {16'h0000, 16'h0000, 16'h0000, 16'h0000}, 16'h0000},
      '{ROW_STEP_CHECK, CSR_SLICE_SHORT,  24'd0,
        {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 16'hFFFC},
      '{ROW_STEP_CHECK, CSR_SLICE_SHORT,  24'd0,
        {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 16'h0000},
      '{ROW_STEP_CHECK, CSR_SLICE_SHORT,  24'd0,
        {16'h7FFF, 16'h0001, 16'h0000, 16'h0000}, 16'h8000},
      '{ROW_STEP_CHECK, CSR_SLICE_SHORT,  24'd0,
        {16'h5555, 16'hAAAA, 16'h0000, 16'h0000}, 16'hFFFF},
      // No lane mixed at all.
      '{ROW_WRITE,      CSR_ACTIVE_LANES, 24'd0, NO_LANES, 16'h0000},
      '{ROW_STEP_CHECK, CSR_SLICE_SHORT,  24'd0,
        {16'h1234, 16'h0001, 16'h0001, 16'h0001}, 16'h0000},
      // A lane count above four mixes all four.
      '{ROW_WRITE,      CSR_ACTIVE_LANES, 24'd7, NO_LANES, 16'h0000},
      '{ROW_STEP_CHECK, CSR_SLICE_SHORT,  24'd0,
        {16'h0001, 16'h0002, 16'h0003, 16'h0004}, 16'h000A},
      '{ROW_WRITE,      CSR_ACTIVE_LANES, 24'd2, NO_LANES, 16'h0000},
      '{ROW_STEP_CHECK, CSR_SLICE_SHORT,  24'd0,
        {16'h0064, 16'h00C8, 16'h03E7, 16'h03E7}, 16'h012C},
      // A slice of zero behaves as a slice of one.
      '{ROW_WRITE,      CSR_ACTIVE_LANES, 24'd1, NO_LANES, 16'h0000},
      '{ROW_WRITE,      CSR_SLICE_SHORT,  24'd0, NO_LANES, 16'h0000},
      '{ROW_STEP_CHECK, CSR_SLICE_SHORT,  24'd0,
        {16'h0005, 16'h0009, 16'h0009, 16'h0009}, 16'h0005},
      // Division truncates toward zero in both directions.
      '{ROW_WRITE,      CSR_SLICE_SHORT,  24'd2, NO_LANES, 16'h0000},
      '{ROW_STEP,       CSR_SLICE_SHORT,  24'd0,
        {16'hFFFD, 16'h0007, 16'h0007, 16'h0007}, 16'h0000},
      '{ROW_STEP_CHECK, CSR_SLICE_SHORT,  24'd0,
        {16'h0000, 16'h0007, 16'h0007, 16'h0007}, 16'hFFFF},
      '{ROW_STEP,       CSR_SLICE_SHORT,  24'd0,
        {16'h0003, 16'h0000, 16'h0000, 16'h0000}, 16'h0000},
      '{ROW_STEP_CHECK, CSR_SLICE_SHORT,  24'd0,
        {16'h0000, 16'h0000, 16'h0000, 16'h0000}, 16'h0001},
      '{ROW_WRITE,      CSR_SLICE_SHORT,  24'd3, NO_LANES, 16'h0000},
      '{ROW_STEP,       CSR_SLICE_SHORT,  24'd0,
        {16'h8000, 16'h0000, 16'h0000, 16'h0000}, 16'h0000},
      '{ROW_STEP,       CSR_SLICE_SHORT,  24'd0,
        {16'h8000, 16'h0000, 16'h0000, 16'h0000}, 16'h0000},
      '{ROW_STEP_CHECK, CSR_SLICE_SHORT,  24'd0,
        {16'h8000, 16'h0000, 16'h0000, 16'h0000}, 16'h8000},
      // Shortening the slice inside an open window leaves that window at
      // its latched length; the new length applies from the next window.
      '{ROW_STEP,       CSR_SLICE_SHORT,  24'd0,
        {16'h0009, 16'h0000, 16'h0000, 16'h0000}, 16'h0000},
      '{ROW_WRITE,      CSR_SLICE_SHORT,  24'd1, NO_LANES, 16'h0000},
      '{ROW_STEP,       CSR_SLICE_SHORT,  24'd0,
        {16'h0009, 16'h0000, 16'h0000, 16'h0000}, 16'h0000},
      '{ROW_STEP_CHECK, CSR_SLICE_SHORT,  24'd0,
        {16'h0009, 16'h0000, 16'h0000, 16'h0000}, 16'h0009},
      '{ROW_STEP_CHECK, CSR_SLICE_SHORT,  24'd0,
        {16'h0004, 16'h0000, 16'h0000, 16'h0000}, 16'h0004},
      // The phase accumulator goes negative after the first window, so the
      // second window takes the long slice.
      '{ROW_WRITE,      CSR_SLICE_SHORT,  24'd2, NO_LANES, 16'h0000},
      '{ROW_WRITE,      CSR_SLICE_LONG,   24'd3, NO_LANES, 16'h0000},
      '{ROW_WRITE,      CSR_PHASE_ADD,    24'd3, NO_LANES, 16'h0000},
      '{ROW_WRITE,      CSR_PHASE_SUB,    24'd1, NO_LANES, 16'h0000},
      '{ROW_STEP,       CSR_SLICE_SHORT,  24'd0,
        {16'h1111, 16'h0000, 16'h0000, 16'h0000}, 16'h0000},
      '{ROW_STEP,       CSR_SLICE_SHORT,  24'd0,
        {16'h2222, 16'h0000, 16'h0000, 16'h0000}, 16'h0000},
      '{ROW_STEP,       CSR_SLICE_SHORT,  24'd0,
        {16'h3333, 16'h0000, 16'h0000, 16'h0000}, 16'h0000},
      '{ROW_STEP,       CSR_SLICE_SHORT,  24'd0,
        {16'h4444, 16'h0000, 16'h0000, 16'h0000}, 16'h0000},
      '{ROW_STEP,       CSR_SLICE_SHORT,  24'd0,
        {16'h0123, 16'h0000, 16'h0000, 16'h0000}, 16'h0000}
   };

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   sample_type    req_lane0_sample;
   sample_type    req_lane1_sample;
   sample_type    req_lane2_sample;
   sample_type    req_lane3_sample;
   logic          rsp_valid;
   logic          rsp_ready;
   sample_type    rsp_mixed_sample;
   logic          csr_write_enable;
   logic [2:0]    csr_index;
   logic [23:0]   csr_write_data;

   // Register copies held by the model.
   logic [7:0]    cfg_slice_short;
   logic [7:0]    cfg_slice_long;
   logic [23:0]   cfg_phase_add;
   logic [23:0]   cfg_phase_sub;
   logic [2:0]    cfg_active_lanes;

   // Window state held by the model.
   logic [31:0]   phase_acc;
   int unsigned   win_count;
   int unsigned   win_length;
   longint        win_sum;

   // Averaged samples still owed by the block, oldest first.
   sample_type    pending_mixed [$];

   int unsigned   mismatch_count;
   int unsigned   mixed_seen;
   int unsigned   cycle_count;

   // Handshake pressure, set by the stimulus and read by both channel drivers.
   int unsigned   source_idle_pct;
   int unsigned   sink_stall_pct;
   int unsigned   holdoff_request;

   fractional_boxcar_decimator_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_lane0_sample (req_lane0_sample),
      .req_lane1_sample (req_lane1_sample),
      .req_lane2_sample (req_lane2_sample),
      .req_lane3_sample (req_lane3_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mixed_sample (rsp_mixed_sample),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The run is cut short with an error if it has not finished within the limit.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // Model of one step transfer. A window picks its length from the sign of
   // the phase accumulator when it opens; the step sum of the mixed lanes is
   // added in, and the window that fills up yields its truncated average.
   function automatic bit average_window(input step_lanes_type lanes,
                                         output sample_type mixed);
      int unsigned lanes_used;
      int unsigned len;
      longint      step_sum;
      longint      quotient;
      int          i;
      lanes_used = (32'(cfg_active_lanes) > 32'(LANES)) ? 32'(LANES)
                                                        : 32'(cfg_active_lanes);
      if (win_count == 0) begin
         if (phase_acc[31]) begin
            len       = 32'(cfg_slice_long);
            phase_acc = phase_acc + {8'd0, cfg_phase_add};
         end else begin
            len = 32'(cfg_slice_short);
         end
         win_length = (len == 0) ? 1 : len;
         phase_acc  = phase_acc - {8'd0, cfg_phase_sub};
         win_sum    = 0;
      end
      step_sum = 0;
      for (i = 0; i < lanes_used; i++) begin
         step_sum += longint'($signed(lanes[i]));
      end
      win_sum += step_sum;
      win_count++;
      mixed = '0;
      if (win_count >= win_length) begin
         quotient  = win_sum / longint'(win_length);
         mixed     = quotient[15:0];
         win_count = 0;
         win_sum   = 0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Random step content. Some steps drive every lane to the same extreme so
   // that long windows push the sum towards its limits.
   function automatic step_lanes_type random_lanes(input int unsigned extreme_pct);
      step_lanes_type lanes;
      int unsigned    pick;
      int             i;
      pick = $urandom_range(99);
      for (i = 0; i < 4; i++) begin
         if (pick < extreme_pct / 2) begin
            lanes[i] = 16'h8000;
         end else if (pick < extreme_pct) begin
            lanes[i] = 16'h7FFF;
         end else begin
            lanes[i] = 16'($urandom);
         end
      end
      return lanes;
   endfunction

   // Offers one step, waits for its transfer and records what it should
   // produce. A typed value in a directed row overrides the model's answer.
   task automatic offer_step(input step_lanes_type lanes, input bit typed,
                             input sample_type typed_mixed);
      sample_type mixed;
      bit         closes;
      while (source_idle_pct != 0 && $urandom_range(99) < source_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_lane0_sample <= lanes[0];
      req_lane1_sample <= lanes[1];
      req_lane2_sample <= lanes[2];
      req_lane3_sample <= lanes[3];
      do @(posedge clock); while (!req_ready);
      closes = average_window(lanes, mixed);
      if (typed) begin
         pending_mixed.push_back(typed_mixed);
      end else if (closes) begin
         pending_mixed.push_back(mixed);
      end
   endtask

   // Stops offering steps until every owed sample has been taken, then lets
   // the given number of quiet cycles pass. Always waits on the clock first,
   // so valid is never lowered and raised within the same time step.
   task automatic drain_results(input int unsigned quiet_cycles);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_mixed.size() != 0);
      repeat (quiet_cycles) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [23:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_SLICE_SHORT:  cfg_slice_short  = value[7:0];
         CSR_SLICE_LONG:   cfg_slice_long   = value[7:0];
         CSR_PHASE_ADD:    cfg_phase_add    = value;
         CSR_PHASE_SUB:    cfg_phase_sub    = value;
         CSR_ACTIVE_LANES: cfg_active_lanes = value[2:0];
         default: ;
      endcase
   endtask

   // Result side: every transfer is checked against the oldest owed sample.
   // Between transfers the ready line follows the current stall rate, or is
   // held low for a whole hold-off stretch when one has been requested.
   initial begin : result_sink
      sample_type  want;
      int unsigned holdoff_left;
      holdoff_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            mixed_seen++;
            if (pending_mixed.size() == 0) begin
               $display("%0t: mixed_sample %0d transferred with nothing expected",
                        $time, rsp_mixed_sample);
               mismatch_count++;
            end else begin
               want = pending_mixed.pop_front();
               if (rsp_mixed_sample !== want) begin
                  $display("%0t: mixed_sample mismatch, expected %0d, actual %0d",
                           $time, want, rsp_mixed_sample);
                  mismatch_count++;
               end
            end
         end
         if (holdoff_request != 0) begin
            holdoff_left    = holdoff_request;
            holdoff_request = 0;
         end
         if (holdoff_left != 0) begin
            holdoff_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   initial begin : stimulus
      table_row_type row;
      int unsigned   row_no;
      int unsigned   phase_no;
      int unsigned   item_no;
      int unsigned   item_total;
      int unsigned   extreme_pct;
      logic [23:0]   short_len;
      logic [23:0]   long_len;
      logic [23:0]   add_step;
      logic [23:0]   sub_step;
      logic [23:0]   lane_count;

      // Model starts from the register defaults and an empty window.
      cfg_slice_short  = 8'd81;
      cfg_slice_long   = 8'd82;
      cfg_phase_add    = 24'd0;
      cfg_phase_sub    = 24'd0;
      cfg_active_lanes = 3'd1;
      phase_acc        = 32'd0;
      win_count        = 0;
      win_length       = 0;
      win_sum          = 0;
      mismatch_count   = 0;
      mixed_seen       = 0;
      source_idle_pct  = 0;
      sink_stall_pct   = 0;
      holdoff_request  = 0;

      // Every input of the block is known from time zero.
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_lane0_sample <= '0;
      req_lane1_sample <= '0;
      req_lane2_sample <= '0;
      req_lane3_sample <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_SLICE_SHORT;
      csr_write_data   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed table. Register rows wait until the block has nothing left
      // in flight; step rows go straight through the handshake.
      for (row_no = 0; row_no < DIRECTED_ROW_COUNT; row_no++) begin
         row = DIRECTED_ROWS[row_no];
         if (row.kind == ROW_WRITE) begin
            drain_results(SETTLE_CYCLES);
            write_register(row.index, row.value);
         end else begin
            offer_step(row.lanes, row.kind == ROW_STEP_CHECK, row.mixed);
         end
      end

      // Random phases. The first three settle the extremes: the shortest
      // windows, the longest windows with full-scale phase steps, and a
      // pressure phase with short windows while the receiver holds off.
      // Later phases draw their registers at random, mostly with short
      // windows so that results stay plentiful. The idle pattern cycles
      // through none, sender only, receiver only and both.
      for (phase_no = 0;
           phase_no < 12 || (mixed_seen < MIN_RESULTS && phase_no < 40);
           phase_no++) begin
         drain_results(SETTLE_CYCLES);
         case (phase_no)
            0: begin
               short_len = 24'd1;  long_len = 24'd1;
               add_step  = 24'd0;  sub_step = 24'd0;   lane_count = 24'd4;
            end
            1: begin
               short_len = 24'd255;     long_len = 24'd255;
               add_step  = 24'hFFFFFF;  sub_step = 24'hFFFFFF;
               lane_count = 24'd4;
            end
            2: begin
               short_len = 24'd1;  long_len = 24'd2;
               add_step  = 24'd2;  sub_step = 24'd1;   lane_count = 24'd3;
            end
            default: begin
               short_len = 24'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                        : $urandom_range(1, 10));
               long_len  = 24'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                        : $urandom_range(1, 10));
               if ($urandom_range(1) == 0) begin
                  add_step = 24'($urandom_range(300));
                  sub_step = 24'($urandom_range(300));
               end else begin
                  add_step = 24'($urandom);
                  sub_step = 24'($urandom);
               end
               lane_count = 24'($urandom_range(7));
            end
         endcase
         write_register(CSR_SLICE_SHORT,  short_len);
         write_register(CSR_SLICE_LONG,   long_len);
         write_register(CSR_PHASE_ADD,    add_step);
         write_register(CSR_PHASE_SUB,    sub_step);
         write_register(CSR_ACTIVE_LANES, lane_count);

         case (phase_no % 4)
            0: begin source_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin source_idle_pct = 72; sink_stall_pct = 0;  end
            2: begin source_idle_pct = 0;  sink_stall_pct = 72; end
            default: begin source_idle_pct = 32; sink_stall_pct = 32; end
         endcase

         // A long hold-off on the result side while steps keep coming fills
         // the divider, which holds its result, so the step channel stalls.
         if (phase_no == 2) begin
            holdoff_request = 300;
         end

         item_total  = (phase_no == 1) ? 520 : 160;
         extreme_pct = (phase_no == 1) ? 90 : 10;
         for (item_no = 0; item_no < item_total; item_no++) begin
            // Halfway through, the sender pauses until the output side has
            // caught up completely.
            if (item_no == item_total / 2) begin
               drain_results(0);
            end
            offer_step(random_lanes(extreme_pct), 1'b0, sample_type'(0));
         end
      end

      source_idle_pct = 0;
      drain_results(SETTLE_CYCLES);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
